>>> hw/rtl/adc_ladder_key_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ladder keypad decoder
// Shared concurrent-check shorthands; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef ADC_LADDER_KEY_DECODER_DEFINES_SVH
`define ADC_LADDER_KEY_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define AKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("akd check failed");

// Next-cycle implication, disabled during reset
`define AKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("akd check failed");

`endif

>>> hw/rtl/akd_pkg.sv
// ----------------------------------------------------------------------------
// akd_pkg
// Types, ladder tables and register codes for the ladder keypad decoder.
// ----------------------------------------------------------------------------
package akd_pkg;

  // Ladder sizes
  localparam int NKEY5 = 5;
  localparam int NKEY7 = 7;

  // Thresholds, highest first, and the raw code each one gives
  localparam logic [7:0] THR5  [NKEY5] = '{8'd72, 8'd52, 8'd33, 8'd12, 8'd0};
  localparam logic [2:0] CODE5 [NKEY5] = '{3'd0, 3'd4, 3'd5, 3'd2, 3'd1};
  localparam logic [7:0] THR7  [NKEY7] =
    '{8'd190, 8'd164, 8'd148, 8'd134, 8'd120, 8'd106, 8'd94};
  localparam logic [2:0] CODE7 [NKEY7] = '{3'd0, 3'd5, 3'd4, 3'd0, 3'd0, 3'd1, 3'd2};

  // Release levels ("no key pressed")
  localparam logic [7:0] REL5 = 8'd72;
  localparam logic [7:0] REL7 = 8'd200;

  // Reported code for two keys at once
  localparam logic [7:0] CONFLICT_CODE = 8'hFF;
  // Key that lights the backlight outside standby
  localparam logic [2:0] WAKE_KEY = 3'd1;

  // Register index (paddr[2])
  localparam logic REG_LADDER = 1'b0;
  localparam logic REG_WAKE   = 1'b1;

  typedef struct packed {
    logic ladder_select;
    logic wake_on_key;
  } cfg_t;

  typedef struct packed {
    logic [7:0] adc_value;
    logic       touch_hold;
    logic       standby;
    logic       backlight_on;
  } item_t;

  typedef struct packed {
    logic       release_lvl;
    logic       hit;
    logic [2:0] code;
  } match_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       backlight_set;
    logic       locked;
  } res_t;

endpackage

>>> hw/rtl/akd_ladder.sv
// ----------------------------------------------------------------------------
// akd_ladder
// Parallel threshold compare: release detect and first-threshold key code.
// ----------------------------------------------------------------------------
module akd_ladder (
  input  logic                  ladder_select,
  input  logic [7:0]            adc_value,
  output akd_pkg::match_t       match
);

  logic       hit5, hit7;
  logic [2:0] code5, code7;

  // 5-key ladder: scan from lowest threshold up so the highest hit wins
  always_comb begin
    hit5  = 1'b0;
    code5 = '0;
    for (int i = akd_pkg::NKEY5 - 1; i >= 0; i--) begin
      if (adc_value >= akd_pkg::THR5[i]) begin
        hit5  = 1'b1;
        code5 = akd_pkg::CODE5[i];
      end
    end
  end

  // 7-key ladder
  always_comb begin
    hit7  = 1'b0;
    code7 = '0;
    for (int i = akd_pkg::NKEY7 - 1; i >= 0; i--) begin
      if (adc_value >= akd_pkg::THR7[i]) begin
        hit7  = 1'b1;
        code7 = akd_pkg::CODE7[i];
      end
    end
  end

  // Select ladder
  always_comb begin
    if (ladder_select) begin
      match.release_lvl = (adc_value >= akd_pkg::REL7);
      match.hit         = hit7;
      match.code        = code7;
    end else begin
      match.release_lvl = (adc_value >= akd_pkg::REL5);
      match.hit         = hit5;
      match.code        = code5;
    end
  end

endmodule

>>> hw/rtl/akd_core.sv
// ----------------------------------------------------------------------------
// akd_core
// Debounce, lock and backlight-wake state; produces one result per beat.
// ----------------------------------------------------------------------------
`include "adc_ladder_key_decoder_defines.svh"

module akd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  akd_pkg::item_t  item,
  input  akd_pkg::match_t match,
  input  akd_pkg::cfg_t   cfg,
  output akd_pkg::res_t   res
);

  logic       lock_r, lock_nxt;
  logic [2:0] prev_r, prev_nxt;
  logic [2:0] acc_r, acc_nxt;
  logic [2:0] rep_r, rep_nxt;      // reported key 0..5
  logic       conf_r, conf_nxt;    // reported key is the conflict code
  logic       bl;                  // backlight flag after this beat
  logic       bl_lit;

  // Next-state logic for one sample
  always_comb begin
    lock_nxt = lock_r;
    prev_nxt = prev_r;
    acc_nxt  = acc_r;
    rep_nxt  = rep_r;
    conf_nxt = conf_r;
    bl       = item.backlight_on;
    bl_lit   = item.backlight_on ||
               (prev_r == akd_pkg::WAKE_KEY && cfg.wake_on_key && !item.standby);
    if (!item.touch_hold) begin
      priority if (match.release_lvl) begin
        lock_nxt = 1'b0;
        prev_nxt = '0;
        acc_nxt  = '0;
        rep_nxt  = '0;
        conf_nxt = 1'b0;
      end else if (!lock_r && match.hit) begin
        priority if (prev_r != match.code) begin
          prev_nxt = match.code;
        end else if (acc_r == '0 || prev_r == acc_r) begin
          // Second equal sample: accept the key
          acc_nxt = prev_r;
          bl      = bl_lit;
          if (!bl_lit) begin
            if (!cfg.wake_on_key || item.standby) begin
              // Key only wakes the backlight
              lock_nxt = 1'b1;
              bl       = 1'b1;
              rep_nxt  = '0;
              conf_nxt = 1'b0;
            end
          end else begin
            rep_nxt  = prev_r;
            conf_nxt = 1'b0;
          end
        end else begin
          // Different key while another is held
          lock_nxt = 1'b1;
          conf_nxt = 1'b1;
        end
      end else begin
        // Locked with the key still held, or under every threshold: no change
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= 1'b0;
      prev_r <= '0;
      acc_r  <= '0;
      rep_r  <= '0;
      conf_r <= 1'b0;
    end else if (fire) begin
      lock_r <= lock_nxt;
      prev_r <= prev_nxt;
      acc_r  <= acc_nxt;
      rep_r  <= rep_nxt;
      conf_r <= conf_nxt;
    end
  end

  // Result for this beat
  assign res.key_code      = conf_nxt ? akd_pkg::CONFLICT_CODE : {5'd0, rep_nxt};
  assign res.backlight_set = bl && !item.backlight_on;
  assign res.locked        = lock_nxt;

  // Checks
  `AKD_ASSERT_NOW(a_conf_locked, conf_r, lock_r)
  `AKD_ASSERT_NOW(a_rep_is_acc, (rep_r != '0), (rep_r == acc_r))
  `AKD_ASSERT_NEXT(a_release_clr, (fire && !item.touch_hold && match.release_lvl),
                   (!lock_r && prev_r == '0 && acc_r == '0 && rep_r == '0 && !conf_r))
  `AKD_ASSERT_NEXT(a_hold_keeps, (fire && item.touch_hold),
                   $stable({lock_r, prev_r, acc_r, rep_r, conf_r}))

endmodule

>>> hw/rtl/adc_ladder_key_decoder.sv
// ----------------------------------------------------------------------------
// adc_ladder_key_decoder
// Resistor-ladder keypad decoder: ADC sample in, debounced key code out.
// ----------------------------------------------------------------------------
// The compare and flag update fit one stage, between input reg and result reg.
// Throughput: one sample per cycle while the result channel is not stalled.
// A stalled result holds; one more sample waits in the input register.
// Reset (rst_n low, synchronous): pipeline empty, key state cleared,
// ladder_select = 0, wake_on_key = 1.
module adc_ladder_key_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_adc_value,
  input  logic        in_touch_hold,
  input  logic        in_standby,
  input  logic        in_backlight_on,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_key_code,
  output logic        out_backlight_set,
  output logic        out_locked,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  akd_pkg::cfg_t   cfg_r;
  akd_pkg::item_t  item_r;
  akd_pkg::match_t match;
  akd_pkg::res_t   res, res_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            s1_adv, s1_fire, in_acc, cfg_wr;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ladder_select <= 1'b0;
      cfg_r.wake_on_key   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        akd_pkg::REG_LADDER: cfg_r.ladder_select <= cfg_pwdata[0];
        akd_pkg::REG_WAKE:   cfg_r.wake_on_key   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      akd_pkg::REG_LADDER: cfg_prdata = {31'd0, cfg_r.ladder_select};
      akd_pkg::REG_WAKE:   cfg_prdata = {31'd0, cfg_r.wake_on_key};
      default:             cfg_prdata = '0;
    endcase
  end

  // Handshake: input stage moves when the result register is free or drains
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_fire || (out_valid_r && out_stall);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.adc_value    <= in_adc_value;
      item_r.touch_hold   <= in_touch_hold;
      item_r.standby      <= in_standby;
      item_r.backlight_on <= in_backlight_on;
    end
  end

  // Threshold compare and state update
  akd_ladder u_ladder (
    .ladder_select (cfg_r.ladder_select),
    .adc_value     (item_r.adc_value),
    .match         (match)
  );

  akd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .item  (item_r),
    .match (match),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_code      = res_r.key_code;
  assign out_backlight_set = res_r.backlight_set;
  assign out_locked        = res_r.locked;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ladder keypad decoder testbench
// Drives ADC samples through the sample channel under random idle and stall,
// predicts each result beat with an in-bench model of the key debounce and
// lock logic, and compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;

  localparam int       IDLE_LIMIT   = 4000;
  localparam logic [2:0] KEY_NONE   = 3'd0;
  localparam logic [2:0] KEY_LIGHT  = 3'd1;
  localparam logic [7:0] KEY_CLASH  = 8'hFF;
  localparam logic [7:0] RELEASE_5  = 8'd72;
  localparam logic [7:0] RELEASE_7  = 8'd200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_adc_value = 8'd0;
  logic        in_touch_hold = 1'b0;
  logic        in_standby = 1'b0;
  logic        in_backlight_on = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_key_code;
  logic        out_backlight_set;
  logic        out_locked;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted decoder state and register copies (reset values)
  logic       cfg_ladder7 = 1'b0;
  logic       cfg_wake = 1'b1;
  logic       held_lock = 1'b0;
  logic [2:0] last_raw = KEY_NONE;
  logic [2:0] confirmed_key = KEY_NONE;
  logic [7:0] shown_code = 8'd0;

  akd_pkg::res_t pending_reports[$];
  int   err_count = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  int   quiet_cycles = 0;

  always #10 clk = ~clk;

  adc_ladder_key_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_adc_value     (in_adc_value),
    .in_touch_hold    (in_touch_hold),
    .in_standby       (in_standby),
    .in_backlight_on  (in_backlight_on),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_code     (out_key_code),
    .out_backlight_set(out_backlight_set),
    .out_locked       (out_locked),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // Threshold search, highest level first; returns 0 when nothing is reached
  function automatic logic ladder_hit(input logic seven, input logic [7:0] s,
                                      output logic [2:0] code);
    ladder_hit = 1'b1;
    code = 3'd0;
    if (!seven) begin
      if (s >= 8'd72)      code = 3'd0;
      else if (s >= 8'd52) code = 3'd4;
      else if (s >= 8'd33) code = 3'd5;
      else if (s >= 8'd12) code = 3'd2;
      else                 code = 3'd1;
    end else begin
      if (s >= 8'd190)      code = 3'd0;
      else if (s >= 8'd164) code = 3'd5;
      else if (s >= 8'd148) code = 3'd4;
      else if (s >= 8'd134) code = 3'd0;
      else if (s >= 8'd120) code = 3'd0;
      else if (s >= 8'd106) code = 3'd1;
      else if (s >= 8'd94)  code = 3'd2;
      else                  ladder_hit = 1'b0;
    end
  endfunction

  // Debounce / lock update for one accepted sample; queues the expected beat
  task automatic predict_key_report(input akd_pkg::item_t s);
    logic [7:0]    rel;
    logic [2:0]    raw;
    logic          bl;
    akd_pkg::res_t r;
    rel = cfg_ladder7 ? RELEASE_7 : RELEASE_5;
    bl = s.backlight_on;
    if (!s.touch_hold) begin
      if (s.adc_value >= rel) begin
        held_lock = 1'b0;
        last_raw = KEY_NONE;
        confirmed_key = KEY_NONE;
        shown_code = 8'd0;
      end else if (!held_lock && ladder_hit(cfg_ladder7, s.adc_value, raw)) begin
        if (last_raw != raw) begin
          last_raw = raw;
        end else if (confirmed_key == KEY_NONE || last_raw == confirmed_key) begin
          confirmed_key = last_raw;
          if (last_raw == KEY_LIGHT && cfg_wake && !s.standby) bl = 1'b1;
          if (!bl) begin
            // wake-lock: key only lights the backlight
            if (!cfg_wake || s.standby) begin
              held_lock = 1'b1;
              bl = 1'b1;
              shown_code = 8'd0;
            end
          end else begin
            shown_code = {5'd0, last_raw};
          end
        end else begin
          held_lock = 1'b1;
          shown_code = KEY_CLASH;
        end
      end
    end
    r.key_code = shown_code;
    r.backlight_set = bl && !s.backlight_on;
    r.locked = held_lock;
    pending_reports.push_back(r);
  endtask

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Send one sample beat; starts and ends at a falling edge
  task automatic send_sample(input logic [7:0] adc, input logic hold,
                             input logic stby, input logic bl);
    akd_pkg::item_t s;
    s.adc_value = adc;
    s.touch_hold = hold;
    s.standby = stby;
    s.backlight_on = bl;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_adc_value <= adc;
    in_touch_hold <= hold;
    in_standby <= stby;
    in_backlight_on <= bl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_key_report(s);
    @(negedge clk);
  endtask

  // Stop sending and let every expected beat come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == akd_pkg::REG_LADDER) cfg_ladder7 = value[0];
    else cfg_wake = value[0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_ladder_cfg(input logic [31:0] ladder_word,
                                input logic [31:0] wake_word);
    wait_idle();
    write_reg(akd_pkg::REG_LADDER, ladder_word);
    write_reg(akd_pkg::REG_WAKE, wake_word);
  endtask

  // 5-key ladder at reset settings: wake key, conflict, hold, wake-lock
  task automatic test_five_key_ladder();
    send_sample(8'd255, 1'b0, 1'b0, 1'b1);  // release, top of range
    send_sample(8'd0,   1'b0, 1'b0, 1'b1);  // first sight of key 1
    send_sample(8'd0,   1'b1, 1'b0, 1'b1);  // touch hold, ignored
    send_sample(8'd0,   1'b0, 1'b0, 1'b1);  // key 1 confirmed
    send_sample(8'd71,  1'b0, 1'b0, 1'b1);  // second key appears
    send_sample(8'd71,  1'b0, 1'b0, 1'b1);  // conflict lock
    send_sample(8'd20,  1'b0, 1'b0, 1'b1);  // locked, key held
    send_sample(8'd72,  1'b0, 1'b0, 1'b1);  // release exactly at level
    send_sample(8'd52,  1'b0, 1'b1, 1'b0);
    send_sample(8'd52,  1'b0, 1'b1, 1'b0);  // wake-lock in standby
    send_sample(8'd200, 1'b0, 1'b0, 1'b0);
    send_sample(8'd12,  1'b0, 1'b0, 1'b0);
    send_sample(8'd12,  1'b0, 1'b0, 1'b0);  // dark, awake: nothing shown
    send_sample(8'd128, 1'b0, 1'b0, 1'b0);
    send_sample(8'd0,   1'b0, 1'b0, 1'b0);
    send_sample(8'd0,   1'b0, 1'b0, 1'b0);  // key 1 lights the backlight
  endtask

  // 7-key ladder with wake_on_key off; upper data bits set on both writes
  task automatic test_seven_key_ladder();
    set_ladder_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_sample(8'd93,  1'b0, 1'b0, 1'b1);  // under every threshold
    send_sample(8'd255, 1'b0, 1'b0, 1'b1);
    send_sample(8'd199, 1'b0, 1'b0, 1'b1);  // raw code zero confirms a 0
    send_sample(8'd200, 1'b0, 1'b0, 1'b1);
    send_sample(8'd134, 1'b0, 1'b0, 1'b0);  // raw zero triggers wake-lock
    send_sample(8'd94,  1'b0, 1'b0, 1'b0);  // locked, nothing changes
    send_sample(8'd220, 1'b0, 1'b0, 1'b1);
    send_sample(8'd106, 1'b0, 1'b1, 1'b1);
    send_sample(8'd106, 1'b0, 1'b1, 1'b1);
    send_sample(8'd94,  1'b1, 1'b0, 1'b1);
  endtask

  // Random presses: a key level held for a few beats, often then released,
  // mixed with some fully random samples
  task automatic test_random_presses(input int count, input logic ladder,
                                     input logic wake);
    int         sent;
    int         rel;
    int         lo;
    int         reps;
    logic [7:0] lvl;
    logic       stby;
    logic       bl;
    set_ladder_cfg({$urandom} & ~32'd1 | {31'd0, ladder},
                   {$urandom} & ~32'd1 | {31'd0, wake});
    rel = int'(ladder ? RELEASE_7 : RELEASE_5);
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_sample(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        lo = (ladder && $urandom_range(0, 1)) ? 94 : 0;
        lvl = 8'($urandom_range(lo, rel - 1));
        reps = $urandom_range(1, 4);
        stby = ($urandom_range(0, 3) == 0);
        bl = ($urandom_range(0, 9) < 7);
        repeat (reps) begin
          send_sample(lvl, $urandom_range(0, 11) == 0, stby, bl);
          sent++;
        end
        if ($urandom_range(0, 9) < 6) begin
          send_sample(8'($urandom_range(rel, 255)), 1'b0, stby, bl);
          sent++;
        end
      end
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  // Receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
  end

  // Result checker: each result beat against the oldest expectation
  always @(posedge clk) begin
    akd_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_error("result beat with nothing expected");
      end else begin
        want = pending_reports.pop_front();
        if (out_key_code !== want.key_code)
          report_error($sformatf("key_code %0d, expected %0d",
                                 out_key_code, want.key_code));
        if (out_backlight_set !== want.backlight_set)
          report_error($sformatf("backlight_set %0b, expected %0b",
                                 out_backlight_set, want.backlight_set));
        if (out_locked !== want.locked)
          report_error($sformatf("locked %0b, expected %0b",
                                 out_locked, want.locked));
      end
    end
  end

  // Watchdog: too long with no beat on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 17;
    snk_stall_pct = 62;
    test_five_key_ladder();
    test_seven_key_ladder();
    test_random_presses(225, 1'b0, 1'b1);
    test_random_presses(225, 1'b1, 1'b0);

    src_idle_pct = 62;
    snk_stall_pct = 17;
    test_random_presses(225, 1'b1, 1'b1);
    test_random_presses(225, 1'b0, 1'b0);

    src_idle_pct = 0;
    snk_stall_pct = 0;
    test_random_presses(225, 1'b1, 1'b0);
    test_random_presses(225, 1'b0, 1'b1);

    wait_idle();
    repeat (6) @(negedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
